/* hw/rtl/lpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned MAX_W     = 17;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned PHASE_W   = 2;

   localparam logic [MAX_W-1:0] MAX_TOTAL_RESET = 17'd1024;
   localparam logic [MAX_W-1:0] HEADER_BYTES    = 17'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HEADER    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PAYLOAD   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ERROR  = 2'd0;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [LEN_W-1:0]    frame_length;
      logic                last_of_frame;
   } rsp_type;

endpackage : lpd_pkg

`default_nettype wire

/* hw/rtl/length_prefix_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Result path: the result of an accepted request is registered and shows on rsp_* in the cycle after it is accepted.
// Throughput: one request per cycle; the single result register refills as it drains,
//   so the only stall comes from rsp_tready held low.
// Reset (synchronous, active high): parser returns to the first header byte, sticky
//   error cleared, result register emptied, max_frame_total back to 1024.

module length_prefix_deframer (
   input  wire logic                         clock,
   input  wire logic                         reset,

   // config write: max_frame_total
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [lpd_pkg::MAX_W-1:0]    csr_data,

   // request stream
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,  // [7:0] data_byte

   // result stream
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [23:0]                       rsp_tdata,  // [7:0] payload_byte,
                                                         // [23:8] frame_length
   output logic [1:0]                        rsp_tuser,  // [1:0] status
   output logic                              rsp_tlast   // last_of_frame
);
   import lpd_pkg::*;

   logic [MAX_W-1:0] max_total_ff;
   logic             req_accept;
   logic             can_load;
   rsp_type          parse_result;
   rsp_type          out_result;

   // config register, written any cycle; only meaningful while idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= MAX_TOTAL_RESET;
      end else if (csr_valid) begin
         max_total_ff <= csr_data;
      end
   end

   // ready is just "result slot free or freeing", not an idle state
   assign req_tready = can_load;
   assign req_accept = req_tvalid && can_load;

   // header/payload tracking and length checks, one byte per request
   lpd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .data_byte       (req_tdata),
      .max_frame_total (max_total_ff),
      .result          (parse_result)
   );

   // result register between parser and rsp side
   lpd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .result     (parse_result),
      .can_load   (can_load),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {out_result.frame_length, out_result.payload_byte};
   assign rsp_tuser = out_result.status;
   assign rsp_tlast = out_result.last_of_frame;

endmodule : length_prefix_deframer

`default_nettype wire

/* hw/rtl/lpd_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpd_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [lpd_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic [lpd_pkg::MAX_W-1:0]   max_frame_total,
   output lpd_pkg::rsp_type                 result
);
   import lpd_pkg::*;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_LEN_HI  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_LEN_LO  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;

   logic [PHASE_W-1:0]  phase_ff,      phase_in;
   logic [BYTE_W-1:0]   length_high_ff, length_high_in;
   logic [LEN_W-1:0]    cur_len_ff,    cur_len_in;
   logic [LEN_W-1:0]    left_ff,       left_in;
   logic [STATUS_W-1:0] error_ff,      error_in;

   logic [LEN_W-1:0]    new_len;
   logic [MAX_W-1:0]    new_total;
   logic [LEN_W-1:0]    left_dec;

   assign new_len   = {length_high_ff, data_byte};
   assign new_total = {1'b0, new_len} + HEADER_BYTES;
   assign left_dec  = left_ff - 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      length_high_in = length_high_ff;
      cur_len_in     = cur_len_ff;
      left_in        = left_ff;
      error_in       = error_ff;
      result         = '0;

      if (error_ff != ST_NO_ERROR) begin
         // sticky error: repeat the code, drop the byte
         result.status       = error_ff;
         result.frame_length = cur_len_ff;
      end else begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               cur_len_in          = new_len;
               result.frame_length = new_len;
               if (new_len == '0) begin
                  error_in      = ST_ZERO_LEN;
                  result.status = ST_ZERO_LEN;
               end else if (new_total > max_frame_total) begin
                  error_in      = ST_TOO_LARGE;
                  result.status = ST_TOO_LARGE;
               end else begin
                  left_in       = new_len;
                  phase_in      = PH_PAYLOAD;
                  result.status = ST_HEADER;
               end
            end
            PH_PAYLOAD: begin
               left_in              = left_dec;
               result.status        = ST_PAYLOAD;
               result.payload_byte  = data_byte;
               result.frame_length  = cur_len_ff;
               result.last_of_frame = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = PH_LEN_HI;
               end
            end
            default: begin
               // high length byte (unused code behaves the same)
               length_high_in = data_byte;
               cur_len_in     = '0;
               phase_in       = PH_LEN_LO;
               result.status  = ST_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEN_HI;
         length_high_ff <= '0;
         cur_len_ff     <= '0;
         left_ff        <= '0;
         error_ff       <= ST_NO_ERROR;
      end else if (accept) begin
         phase_ff       <= phase_in;
         length_high_ff <= length_high_in;
         cur_len_ff     <= cur_len_in;
         left_ff        <= left_in;
         error_ff       <= error_in;
      end
   end

endmodule : lpd_parser

`default_nettype wire

/* hw/rtl/lpd_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpd_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire lpd_pkg::rsp_type  result,
   output logic                   can_load,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output lpd_pkg::rsp_type       out_result
);
   import lpd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // a new result may enter when the slot is empty or drains this cycle
   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = data_ff;

endmodule : lpd_out_reg

`default_nettype wire
